// ===== hdl/bmhtk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmhtk_pkg;

  // Heap geometry
  localparam int CAPACITY     = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int K_MAX        = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;
  localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W       = $clog2(CAPACITY + 1);
  localparam int LC_W         = SLOT_W + 1;
  localparam int CFG_W        = 5;

  // Payload
  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam logic [KEY_W-1:0] SENTINEL_KEY = {(KEY_W / 8){8'h7f}};

  // Input and result codes
  localparam logic OP_OFFER   = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_root;
    logic off_start;
    logic rd_child;
    logic wr_cand;
    logic wr_child;
    logic dr_init;
    logic rd_sort;
    logic dr_load;
    logic wr_top;
    logic em_init;
    logic rd_emit;
    logic emit_entry;
    logic emit_ack;
    logic ack_val;
    logic clear_heap;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_drain;
    logic root_less;
    logic leaf;
    logic stop;
    logic sort_last;
    logic emit_last;
  } status_t;

  // Saturate a written k into 1..K_MAX
  function automatic logic [SLOT_W-1:0] clamp_k(input logic [CFG_W-1:0] v);
    logic [SLOT_W-1:0] r;
    if (v == '0) begin
      r = SLOT_W'(1);
    end else if (int'(v) > K_MAX) begin
      r = SLOT_W'(K_MAX);
    end else begin
      r = SLOT_W'(v);
    end
    return r;
  endfunction

  // Map a 1-based heap slot to a memory address
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LC_W-1:0] slot);
    logic [LC_W-1:0] t;
    t = slot - LC_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bmhtk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhtk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bmhtk_pkg::status_t status,
  output bmhtk_pkg::cmd_t    cmd,
  output logic              busy
);
  import bmhtk_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_OFF_CMP  = 4'd1;
  localparam logic [3:0] S_SIFT_RD  = 4'd2;
  localparam logic [3:0] S_SIFT_CMP = 4'd3;
  localparam logic [3:0] S_DR_RD    = 4'd4;
  localparam logic [3:0] S_DR_LD    = 4'd5;
  localparam logic [3:0] S_DR_WR    = 4'd6;
  localparam logic [3:0] S_EM_RD    = 4'd7;
  localparam logic [3:0] S_EM_OUT   = 4'd8;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          cmd.rd_root   = 1'b1;
          cmd.dr_init   = 1'b1;
          state_next    = S_OFF_CMP;
        end
      end
      S_OFF_CMP: begin
        if (status.is_drain) begin
          state_next = S_DR_RD;
        end else if (status.root_less) begin
          cmd.off_start = 1'b1;
          state_next    = S_SIFT_RD;
        end else begin
          cmd.emit_ack = 1'b1;
          cmd.ack_val  = 1'b0;
          state_next   = S_IDLE;
        end
      end
      S_SIFT_RD: begin
        if (status.leaf) begin
          cmd.wr_cand = 1'b1;
          if (status.is_drain) begin
            state_next = S_DR_WR;
          end else begin
            cmd.emit_ack = 1'b1;
            cmd.ack_val  = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd_child = 1'b1;
          state_next   = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        if (status.stop) begin
          cmd.wr_cand = 1'b1;
          if (status.is_drain) begin
            state_next = S_DR_WR;
          end else begin
            cmd.emit_ack = 1'b1;
            cmd.ack_val  = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.wr_child = 1'b1;
          state_next   = S_SIFT_RD;
        end
      end
      S_DR_RD: begin
        cmd.rd_sort = 1'b1;
        state_next  = S_DR_LD;
      end
      S_DR_LD: begin
        cmd.dr_load = 1'b1;
        state_next  = S_SIFT_RD;
      end
      S_DR_WR: begin
        cmd.wr_top = 1'b1;
        if (status.sort_last) begin
          cmd.em_init = 1'b1;
          state_next  = S_EM_RD;
        end else begin
          state_next = S_DR_RD;
        end
      end
      S_EM_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.emit_entry = 1'b1;
        if (status.emit_last) begin
          cmd.clear_heap = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_EM_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bmhtk_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhtk_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op,
  input  logic [bmhtk_pkg::KEY_W-1:0] cand_key,
  input  logic [bmhtk_pkg::TAG_W-1:0] cand_tag,
  input  logic                        cfg_we,
  input  logic [bmhtk_pkg::CFG_W-1:0] cfg_wdata,
  input  bmhtk_pkg::cmd_t             cmd,
  output bmhtk_pkg::status_t          status,
  output logic                        done,
  output logic                        kind,
  output logic                        accepted,
  output logic [bmhtk_pkg::KEY_W-1:0] entry_key,
  output logic [bmhtk_pkg::TAG_W-1:0] entry_tag,
  output logic                        last
);
  import bmhtk_pkg::*;

  // Heap storage; an entry without its valid bit reads as the sentinel key with a zero tag
  entry_t              mem [CAPACITY];
  logic [CAPACITY-1:0] valid;

  // Control registers
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] empty_cnt;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] n;
  logic [SLOT_W-1:0] n_sort;
  logic [SLOT_W-1:0] e;

  // Payload registers
  logic   drain;
  entry_t cand;
  entry_t top;
  entry_t rd_a;
  entry_t rd_b;

  // Sift-down comparison
  logic [LC_W-1:0]   lc, rc;
  logic              rc_ok, pick_b;
  logic [SLOT_W-1:0] pick_slot;
  entry_t            pick;

  always_comb begin
    lc        = {pos, 1'b0};
    rc        = lc + LC_W'(1);
    rc_ok     = (rc <= LC_W'(n));
    pick_b    = rc_ok && !(rd_a.key > rd_b.key);
    pick_slot = pick_b ? rc[SLOT_W-1:0] : lc[SLOT_W-1:0];
    pick      = pick_b ? rd_b : rd_a;
  end

  assign status.is_drain  = drain;
  assign status.root_less = (cand.key < rd_a.key);
  assign status.leaf      = (lc > LC_W'(n));
  assign status.stop      = (pick.key < cand.key);
  assign status.sort_last = (n_sort == SLOT_W'(1));
  assign status.emit_last = (e == k);

  // Read and write port selection
  logic              rd_en, we;
  logic [LC_W-1:0]   ra_slot, rb_slot, w_slot;
  logic [ADDR_W-1:0] ra, rb, wa;
  entry_t            wdata;

  always_comb begin
    rd_en   = cmd.rd_root | cmd.rd_child | cmd.rd_sort | cmd.rd_emit;
    ra_slot = LC_W'(1);
    rb_slot = LC_W'(n_sort);
    if (cmd.rd_child) begin
      ra_slot = lc;
      rb_slot = rc;
    end else if (cmd.rd_emit) begin
      ra_slot = LC_W'(e);
    end
    we     = cmd.wr_cand | cmd.wr_child | cmd.wr_top;
    w_slot = LC_W'(pos);
    wdata  = cand;
    if (cmd.wr_child) begin
      wdata = pick;
    end else if (cmd.wr_top) begin
      w_slot = LC_W'(n_sort);
      wdata  = top;
    end
    ra = slot_addr(ra_slot);
    rb = slot_addr(rb_slot);
    wa = slot_addr(w_slot);
  end

  // Write the heap memory and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wdata;
    end
    if (rd_en) begin
      rd_a <= valid[ra] ? mem[ra] : '{key: SENTINEL_KEY, tag: '0};
      rd_b <= valid[rb] ? mem[rb] : '{key: SENTINEL_KEY, tag: '0};
    end
  end

  // Control state: valid bits, k, fill count, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      k         <= SLOT_W'(K_MAX);
      empty_cnt <= SLOT_W'(K_MAX);
      done      <= 1'b0;
    end else begin
      done <= cmd.emit_ack | cmd.emit_entry;
      if (cfg_we) begin
        valid     <= '0;
        k         <= clamp_k(cfg_wdata);
        empty_cnt <= clamp_k(cfg_wdata);
      end else if (cmd.clear_heap) begin
        valid     <= '0;
        empty_cnt <= k;
      end else begin
        if (we) begin
          valid[wa] <= 1'b1;
        end
        if (cmd.off_start && (empty_cnt != '0)) begin
          empty_cnt <= empty_cnt - SLOT_W'(1);
        end
      end
    end
  end

  // Sift, sort and emit bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      drain    <= (op == OP_DRAIN);
      cand.key <= cand_key;
      cand.tag <= cand_tag;
    end else if (cmd.dr_load) begin
      cand <= rd_b;
    end
    if (cmd.dr_load) begin
      top <= rd_a;
    end
    if (cmd.off_start) begin
      pos <= (empty_cnt != '0) ? empty_cnt : SLOT_W'(1);
      n   <= k;
    end else if (cmd.dr_load) begin
      pos <= SLOT_W'(1);
      n   <= n_sort - SLOT_W'(1);
    end else if (cmd.wr_child) begin
      pos <= pick_slot;
    end
    if (cmd.dr_init) begin
      n_sort <= k;
    end else if (cmd.wr_top) begin
      n_sort <= n_sort - SLOT_W'(1);
    end
    if (cmd.em_init) begin
      e <= SLOT_W'(1);
    end else if (cmd.emit_entry) begin
      e <= e + SLOT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      kind      <= KIND_ACK;
      accepted  <= cmd.ack_val;
      entry_key <= '0;
      entry_tag <= '0;
      last      <= 1'b1;
    end else if (cmd.emit_entry) begin
      kind      <= KIND_ENTRY;
      accepted  <= 1'b0;
      entry_key <= rd_a.key;
      entry_tag <= rd_a.tag;
      last      <= status.emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bounded_max_heap_top_k.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     start & !busy         op, cand_key, cand_tag
// result    done (one cycle)      kind, accepted, entry_key, entry_tag, last
// config    cfg_we                cfg_wdata (k, saturated to 1..16)
//
// A refused offer reads the root, compares the candidate to it and then
// acknowledges. A taken offer walks down from the next free slot, or from
// the root once the heap is full, and stops at a leaf or on a compare.
// Each level reads both children from the dual-read heap memory, then
// compares and writes one slot. A drain runs an in-place heap sort and then
// emits the k entries from slot 1 upward, in ascending key order.
// Reset, a config write and the end of a drain return every slot to the
// sentinel key at once through per-slot valid bits. The receiver cannot stall.

module bounded_max_heap_top_k (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [bmhtk_pkg::KEY_W-1:0] cand_key,
  input  logic [bmhtk_pkg::TAG_W-1:0] cand_tag,
  input  logic                        cfg_we,
  input  logic [bmhtk_pkg::CFG_W-1:0] cfg_wdata,
  output logic                        done,
  output logic                        kind,
  output logic                        accepted,
  output logic [bmhtk_pkg::KEY_W-1:0] entry_key,
  output logic [bmhtk_pkg::TAG_W-1:0] entry_tag,
  output logic                        last
);
  import bmhtk_pkg::*;

  cmd_t    cmd;
  status_t status;

  bmhtk_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bmhtk_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cand_key  (cand_key),
    .cand_tag  (cand_tag),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .kind      (kind),
    .accepted  (accepted),
    .entry_key (entry_key),
    .entry_tag (entry_tag),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== hdl/bmhtk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhtk_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        kind,
  input logic                        accepted,
  input logic [bmhtk_pkg::KEY_W-1:0] entry_key,
  input logic [bmhtk_pkg::TAG_W-1:0] entry_tag,
  input logic                        last
);
  import bmhtk_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transaction");

  // An offer acknowledgement is a single, final result with no entry payload
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    done && (kind == KIND_ACK) |-> last && (entry_key == '0) && (entry_tag == '0))
    else $error("malformed offer acknowledgement");

  // Drain entries never claim acceptance
  a_entry_acc: assert property (@(posedge clk) disable iff (rst)
    done && (kind == KIND_ENTRY) |-> !accepted)
    else $error("drain entry marked accepted");

  // A drain entry that is not the final one leaves the block busy
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    done && (kind == KIND_ENTRY) && !last |-> busy)
    else $error("block idle in the middle of a drain");

endmodule

bind bounded_max_heap_top_k bmhtk_checker u_bmhtk_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .kind      (kind),
  .accepted  (accepted),
  .entry_key (entry_key),
  .entry_tag (entry_tag),
  .last      (last)
);

`default_nettype wire

// ===== dv/top_k_checker.sv =====
`timescale 1ns / 1ps

module top_k_checker
  import bmhtk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             op,
  input  logic [KEY_W-1:0] cand_key,
  input  logic [TAG_W-1:0] cand_tag,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             done,
  input  logic             kind,
  input  logic             accepted,
  input  logic [KEY_W-1:0] entry_key,
  input  logic [TAG_W-1:0] entry_tag,
  input  logic             last,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic             kind;
    logic             accepted;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } heap_result_t;

  // Shadow heap, slots 1..CAPACITY
  logic [KEY_W-1:0] heap_key [1:CAPACITY];
  logic [TAG_W-1:0] heap_tag [1:CAPACITY];
  int unsigned      free_slots;
  int unsigned      keep_k;
  heap_result_t     heap_out_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Saturate a written k into 1..K_MAX
  function automatic int unsigned saturate_keep(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > K_MAX) return K_MAX;
    return int'(v);
  endfunction

  // Return every slot to the sentinel and start filling from slot k
  function automatic void heap_clear();
    for (int i = 1; i <= CAPACITY; i++) begin
      heap_key[i] = SENTINEL_KEY;
      heap_tag[i] = '0;
    end
    free_slots = keep_k;
  endfunction

  // Sift a key down from slot pos within a heap of n slots; ties go right
  function automatic void heap_sift(input int unsigned n, input int unsigned pos,
                                    input logic [KEY_W-1:0] key,
                                    input logic [TAG_W-1:0] tag);
    int unsigned lc;
    int unsigned pick;
    bit          walking;
    walking = 1'b1;
    while (walking) begin
      lc = pos * 2;
      if (lc > n || lc > CAPACITY) begin
        walking = 1'b0;
      end else begin
        if (lc + 1 > n || lc + 1 > CAPACITY || heap_key[lc] > heap_key[lc + 1]) begin
          pick = lc;
        end else begin
          pick = lc + 1;
        end
        if (heap_key[pick] < key) begin
          walking = 1'b0;
        end else begin
          heap_key[pos] = heap_key[pick];
          heap_tag[pos] = heap_tag[pick];
          pos = pick;
        end
      end
    end
    heap_key[pos] = key;
    heap_tag[pos] = tag;
  endfunction

  // Offer: take the candidate only when it is below the root
  function automatic void heap_offer(input logic [KEY_W-1:0] key,
                                     input logic [TAG_W-1:0] tag);
    heap_result_t r;
    int unsigned  from_slot;
    r = '{kind: KIND_ACK, accepted: 1'b0, key: '0, tag: '0, last: 1'b1};
    if (key < heap_key[1]) begin
      from_slot = 1;
      if (free_slots > 0) begin
        from_slot = free_slots;
        free_slots--;
      end
      heap_sift(keep_k, from_slot, key, tag);
      r.accepted = 1'b1;
    end
    heap_out_q.push_back(r);
  endfunction

  // Drain: in-place heap sort, emit k entries ascending, then clear
  function automatic void heap_drain();
    heap_result_t     r;
    int unsigned      n;
    logic [KEY_W-1:0] top_key;
    logic [TAG_W-1:0] top_tag;
    for (int unsigned i = 0; i < keep_k; i++) begin
      n       = keep_k - i;
      top_key = heap_key[1];
      top_tag = heap_tag[1];
      heap_sift(n - 1, 1, heap_key[n], heap_tag[n]);
      heap_key[n] = top_key;
      heap_tag[n] = top_tag;
    end
    for (int unsigned i = 1; i <= keep_k; i++) begin
      r = '{kind: KIND_ENTRY, accepted: 1'b0, key: heap_key[i], tag: heap_tag[i],
            last: (i == keep_k)};
      heap_out_q.push_back(r);
    end
    heap_clear();
  endfunction

  // Compare one result transaction against the oldest expectation
  task automatic check_result();
    heap_result_t want;
    if (heap_out_q.size() == 0) begin
      flag_mismatch("result with nothing expected, key", entry_key, '0);
    end else begin
      want = heap_out_q.pop_front();
      if (kind !== want.kind) flag_mismatch("kind", 32'(kind), 32'(want.kind));
      if (accepted !== want.accepted) begin
        flag_mismatch("accepted", 32'(accepted), 32'(want.accepted));
      end
      if (entry_key !== want.key) flag_mismatch("entry_key", entry_key, want.key);
      if (entry_tag !== want.tag) flag_mismatch("entry_tag", entry_tag, want.tag);
      if (last !== want.last) flag_mismatch("last", 32'(last), 32'(want.last));
    end
  endtask

  // Watch all channels on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      keep_k = K_MAX;
      heap_clear();
      heap_out_q.delete();
    end else begin
      if (done) check_result();
      if (cfg_we) begin
        keep_k = saturate_keep(cfg_wdata);
        heap_clear();
      end
      if (start && !busy) begin
        if (op == OP_OFFER) begin
          heap_offer(cand_key, cand_tag);
        end else begin
          heap_drain();
        end
      end
    end
    outstanding <= heap_out_q.size();
  end

endmodule

// ===== dv/tb_bounded_max_heap_top_k.sv =====
`timescale 1ns / 1ps

module tb_bounded_max_heap_top_k;
  import bmhtk_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             op;
  logic [KEY_W-1:0] cand_key;
  logic [TAG_W-1:0] cand_tag;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             done;
  logic             kind;
  logic             accepted;
  logic [KEY_W-1:0] entry_key;
  logic [TAG_W-1:0] entry_tag;
  logic             last;

  int fail_count;
  int outstanding;
  int idle_pct;
  int stall_cycles;

  bounded_max_heap_top_k u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .cand_key  (cand_key),
    .cand_tag  (cand_tag),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .kind      (kind),
    .accepted  (accepted),
    .entry_key (entry_key),
    .entry_tag (entry_tag),
    .last      (last)
  );

  top_k_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .cand_key    (cand_key),
    .cand_tag    (cand_tag),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .kind        (kind),
    .accepted    (accepted),
    .entry_key   (entry_key),
    .entry_tag   (entry_tag),
    .last        (last),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one input transaction, after an optional random gap
  task automatic send_item(input logic o, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    op       <= o;
    cand_key <= key;
    cand_tag <= tag;
    do @(posedge clk); while (busy);
  endtask

  // Write k once every expected result is in and the block is idle
  task automatic write_k(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of tie-prone, near-sentinel, full-range and ordinary keys
  function automatic logic [KEY_W-1:0] next_key();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 15);
      2:       return $urandom;
      3:       return SENTINEL_KEY - 1 + $urandom_range(0, 2);
      default: return $urandom_range(0, SENTINEL_KEY - 1);
    endcase
  endfunction

  logic [CFG_W-1:0] k_plan [8] = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd7, 5'd17, 5'd2, 5'd0};
  int               idle_plan [3] = '{0, 82, 8};

  initial begin
    int  sent;
    int  burst;
    logic o;
    rst       = 1'b1;
    start     = 1'b0;
    op        = OP_OFFER;
    cand_key  = '0;
    cand_tag  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: refusals at and above the sentinel, extremes, ties, short drains
    send_item(OP_OFFER, 32'hffff_ffff, 32'h1);
    send_item(OP_OFFER, SENTINEL_KEY, 32'h2);
    send_item(OP_OFFER, SENTINEL_KEY - 1, 32'hffff_ffff);
    send_item(OP_OFFER, 32'h0, 32'h0);
    send_item(OP_OFFER, 32'h5, 32'h3);
    send_item(OP_OFFER, 32'h5, 32'h4);
    send_item(OP_OFFER, 32'h5, 32'h5);
    send_item(OP_DRAIN, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_DRAIN, 32'h0, 32'h0);

    // k written as zero acts as one
    write_k(5'd0);
    send_item(OP_OFFER, 32'h9, 32'haaaa_aaaa);
    send_item(OP_OFFER, 32'h9, 32'h5555_5555);
    send_item(OP_OFFER, 32'h3, 32'h7);
    send_item(OP_OFFER, 32'h8000_0000, 32'h8);
    send_item(OP_DRAIN, 32'h0, 32'h0);

    // Equal keys at k = 2
    write_k(5'd2);
    send_item(OP_OFFER, 32'h7, 32'h10);
    send_item(OP_OFFER, 32'h7, 32'h11);
    send_item(OP_OFFER, 32'h7, 32'h12);
    send_item(OP_OFFER, 32'h6, 32'h13);
    send_item(OP_DRAIN, 32'h0, 32'h0);

    // Random: offer bursts closed by a drain, some stray drains mixed in
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idle_plan[ph % 3];
      write_k((ph == 7) ? CFG_W'($urandom_range(0, 31)) : k_plan[ph]);
      sent = 0;
      while (sent < 14) begin
        burst = $urandom_range(0, 24);
        for (int i = 0; i < burst; i++) begin
          o = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_OFFER;
          send_item(o, next_key(), $urandom);
        end
        send_item(OP_DRAIN, $urandom, $urandom);
        sent += burst + 1;
      end
    end

    // Let every expected result arrive, then allow a quiet tail
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmhtk_pkg.sv
hdl/bmhtk_ctrl.sv
hdl/bmhtk_dpath.sv
hdl/bounded_max_heap_top_k.sv
hdl/bmhtk_checker.sv
dv/top_k_checker.sv
dv/tb_bounded_max_heap_top_k.sv
